// File: design/nbar_pkg.sv
// shared types, register and mode codes, helpers for the nchw boolean axis reduce
`default_nettype none

package nbar_pkg;

    localparam int DIM_W     = 9;
    localparam int DIM_LIMIT = 511;
    localparam int MODE_W    = 3;
    localparam int IDX_W     = 24;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 9;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_DIM_N      = 3'd0;
    localparam logic [CFG_AW-1:0] REG_DIM_C      = 3'd1;
    localparam logic [CFG_AW-1:0] REG_DIM_H      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_DIM_W      = 3'd3;
    localparam logic [CFG_AW-1:0] REG_AXIS_MODE  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_COMBINE_OP = 3'd5;

    // axis modes
    localparam logic [MODE_W-1:0] MODE_N      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_C      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_H      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_W_ONLY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NC     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CH     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_HW     = 3'd6;
    localparam logic [MODE_W-1:0] MODE_ALL    = 3'd7;

    // combine operations
    localparam logic OP_AND = 1'b0;
    localparam logic OP_OR  = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]  dim_n;
        logic [DIM_W-1:0]  dim_c;
        logic [DIM_W-1:0]  dim_h;
        logic [DIM_W-1:0]  dim_w;
        logic [MODE_W-1:0] axis_mode;
        logic              combine_op;
    } nbar_cfg_t;

    // per-word control that rides along the pipe
    typedef struct packed {
        logic valid;
        logic elem;
        logic opens;
        logic closes;
        logic last_all;
    } nbar_tag_t;

    // reduced-axis mask: bit3 n, bit2 c, bit1 h, bit0 w
    function automatic logic [3:0] mode_mask(input logic [MODE_W-1:0] mode);
        logic [3:0] m;
        case (mode)
            MODE_N:      m = 4'b1000;
            MODE_C:      m = 4'b0100;
            MODE_H:      m = 4'b0010;
            MODE_W_ONLY: m = 4'b0001;
            MODE_NC:     m = 4'b1100;
            MODE_CH:     m = 4'b0110;
            MODE_HW:     m = 4'b0011;
            MODE_ALL:    m = 4'b1111;
            default:     m = 4'b1111;
        endcase
        return m;
    endfunction

    // zero acts as one, anything above the cap acts as the cap
    function automatic logic [DIM_W-1:0] clamp_extent(input logic [DIM_W-1:0] d,
                                                      input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] r;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > cap)
            r = cap;
        else
            r = d;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/nbar_pos.sv
// position counters, group open/close flags and the input stage register
`default_nettype none

module nbar_pos #(
    parameter int DIM_MAX = 256,
    parameter int POS_W   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic                                elem,
    input  nbar_pkg::nbar_cfg_t                 cfg,
    output nbar_pkg::nbar_tag_t                 s0_tag,
    output logic [3:0][POS_W-1:0]               s0_pos,
    output logic [3:0][nbar_pkg::DIM_W-1:0]     s0_ext
);
    import nbar_pkg::*;

    localparam int EXT_MAX = (DIM_MAX < DIM_LIMIT) ? DIM_MAX : DIM_LIMIT;

    logic [3:0][POS_W-1:0] pos_reg;
    logic [3:0][POS_W-1:0] pos_next;
    logic [3:0][DIM_W-1:0] ext;
    logic [3:0]            last;
    logic [3:0]            mask;
    logic [3:0][POS_W-1:0] pos_kept;
    logic [3:0][DIM_W-1:0] ext_kept;
    logic                  opens;
    logic                  closes;
    logic                  last_all;
    logic                  carry;
    logic                  accept;

    nbar_tag_t             s0_tag_reg;
    logic [3:0][POS_W-1:0] s0_pos_reg;
    logic [3:0][DIM_W-1:0] s0_ext_reg;

    assign accept = in_valid && adv;

    always_comb
    begin
        mask     = mode_mask(cfg.axis_mode);
        ext[0]   = clamp_extent(cfg.dim_n, DIM_W'(EXT_MAX));
        ext[1]   = clamp_extent(cfg.dim_c, DIM_W'(EXT_MAX));
        ext[2]   = clamp_extent(cfg.dim_h, DIM_W'(EXT_MAX));
        ext[3]   = clamp_extent(cfg.dim_w, DIM_W'(EXT_MAX));
        opens    = 1'b1;
        closes   = 1'b1;
        last_all = 1'b1;
        for (int a = 0; a < 4; a++)
        begin
            last[a] = DIM_W'(pos_reg[a]) >= (ext[a] - DIM_W'(1));
            if (!last[a])
                last_all = 1'b0;
            if (mask[3-a])
            begin
                if (pos_reg[a] != '0)
                    opens = 1'b0;
                if (!last[a])
                    closes = 1'b0;
                pos_kept[a] = '0;
                ext_kept[a] = DIM_W'(1);
            end
            else
            begin
                pos_kept[a] = pos_reg[a];
                ext_kept[a] = ext[a];
            end
        end
        // nchw carry chain, w fastest
        carry = 1'b1;
        for (int a = 3; a >= 0; a--)
        begin
            if (carry)
            begin
                if (last[a])
                    pos_next[a] = '0;
                else
                begin
                    pos_next[a] = pos_reg[a] + POS_W'(1);
                    carry       = 1'b0;
                end
            end
            else
                pos_next[a] = pos_reg[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            s0_tag_reg <= '0;
        end
        else if (adv)
        begin
            if (accept)
                pos_reg <= pos_next;
            s0_tag_reg.valid    <= accept;
            s0_tag_reg.elem     <= elem;
            s0_tag_reg.opens    <= opens;
            s0_tag_reg.closes   <= closes;
            s0_tag_reg.last_all <= last_all;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_pos_reg <= pos_kept;
            s0_ext_reg <= ext_kept;
        end
    end

    assign s0_tag = s0_tag_reg;
    assign s0_pos = s0_pos_reg;
    assign s0_ext = s0_ext_reg;

    // the last word of a tensor brings every position back to the origin
    a_wrap_origin: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_all |=> pos_reg == '0)
        else $error("positions not cleared after last word of tensor");

endmodule

`default_nettype wire

// File: design/nbar_index.sv
// output index horner chain and cell address (index modulo accumulator depth)
`default_nettype none

module nbar_index #(
    parameter int POS_W     = 8,
    parameter int ACC_DEPTH = 4096,
    parameter int CELL_W    = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  nbar_pkg::nbar_tag_t                 s0_tag,
    input  logic [3:0][POS_W-1:0]               s0_pos,
    input  logic [3:0][nbar_pkg::DIM_W-1:0]     s0_ext,
    output nbar_pkg::nbar_tag_t                 s5_tag,
    output logic [nbar_pkg::IDX_W-1:0]          s5_idx,
    output logic [CELL_W-1:0]                   s5_cell
);
    import nbar_pkg::*;

    // reciprocal for the constant modulo; quotient is exact or one low
    localparam int DEPTH_LOG = $clog2(ACC_DEPTH);
    localparam int SH        = IDX_W + DEPTH_LOG;
    localparam int RECIP_W   = IDX_W + 1;
    localparam int PROD_W    = IDX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SH) / 64'(ACC_DEPTH));
    localparam logic [IDX_W-1:0]   DEPTH = IDX_W'(ACC_DEPTH);

    nbar_tag_t        s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg, s5_tag_reg;
    logic [IDX_W-1:0] t1_reg, t2_reg, idx3_reg, idx4_reg, idx5_reg;
    logic [POS_W-1:0] p2_s1_reg, p3_s1_reg, p3_s2_reg;
    logic [DIM_W-1:0] e2_s1_reg, e3_s1_reg, e3_s2_reg;
    logic [IDX_W-1:0] quot_reg;
    logic [CELL_W-1:0] cell_reg;

    logic [IDX_W-1:0]  t1_next, t2_next, idx_next;
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  quot_next;
    logic [IDX_W-1:0]  rem_full;
    logic [IDX_W-1:0]  rem_fix;

    always_comb
    begin
        t1_next   = IDX_W'(s0_pos[0]) * IDX_W'(s0_ext[1]) + IDX_W'(s0_pos[1]);
        t2_next   = t1_reg * IDX_W'(e2_s1_reg) + IDX_W'(p2_s1_reg);
        idx_next  = t2_reg * IDX_W'(e3_s2_reg) + IDX_W'(p3_s2_reg);
        prod      = PROD_W'(idx3_reg) * PROD_W'(RECIP);
        quot_next = IDX_W'(prod >> SH);
        rem_full  = idx4_reg - IDX_W'(quot_reg * DEPTH);
        rem_fix   = (rem_full >= DEPTH) ? (rem_full - DEPTH) : rem_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
            s5_tag_reg <= '0;
        end
        else if (adv)
        begin
            s1_tag_reg <= s0_tag;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
            s4_tag_reg <= s3_tag_reg;
            s5_tag_reg <= s4_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg    <= t1_next;
            p2_s1_reg <= s0_pos[2];
            p3_s1_reg <= s0_pos[3];
            e2_s1_reg <= s0_ext[2];
            e3_s1_reg <= s0_ext[3];
            t2_reg    <= t2_next;
            p3_s2_reg <= p3_s1_reg;
            e3_s2_reg <= e3_s1_reg;
            idx3_reg  <= idx_next;
            idx4_reg  <= idx3_reg;
            quot_reg  <= quot_next;
            idx5_reg  <= idx4_reg;
            cell_reg  <= CELL_W'(rem_fix);
        end
    end

    assign s5_tag  = s5_tag_reg;
    assign s5_idx  = idx5_reg;
    assign s5_cell = cell_reg;

    // a slip in the reciprocal correction shows up as a cell past the end
    a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
        s5_tag_reg.valid |-> ({{(32-CELL_W){1'b0}}, cell_reg} < 32'(ACC_DEPTH)))
        else $error("accumulator cell out of range");

endmodule

`default_nettype wire

// File: design/nbar_acc.sv
// accumulator ram with read-modify-write forwarding and the and/or fold
`default_nettype none

module nbar_acc #(
    parameter int ACC_DEPTH = 4096,
    parameter int CELL_W    = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        combine_op,
    input  nbar_pkg::nbar_tag_t         s5_tag,
    input  logic [nbar_pkg::IDX_W-1:0]  s5_idx,
    input  logic [CELL_W-1:0]           s5_cell,
    output nbar_pkg::nbar_tag_t         m_tag,
    output logic [nbar_pkg::IDX_W-1:0]  m_idx,
    output logic                        m_value
);
    import nbar_pkg::*;

    logic              mem [ACC_DEPTH];
    nbar_tag_t         m_tag_reg;
    logic [IDX_W-1:0]  m_idx_reg;
    logic [CELL_W-1:0] m_cell_reg;
    logic              rd_reg;
    logic              wr_valid_reg;
    logic [CELL_W-1:0] wr_cell_reg;
    logic              wr_val_reg;
    logic              old_val;
    logic              value;

    always_comb
    begin
        // the word ahead wrote this cell on the same edge the read was taken
        old_val = (wr_valid_reg && (wr_cell_reg == m_cell_reg)) ? wr_val_reg : rd_reg;
        if (m_tag_reg.opens)
            value = m_tag_reg.elem;
        else if (combine_op == OP_OR)
            value = old_val | m_tag_reg.elem;
        else
            value = old_val & m_tag_reg.elem;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg <= mem[s5_cell];
            if (m_tag_reg.valid)
                mem[m_cell_reg] <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tag_reg    <= '0;
            wr_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tag_reg    <= s5_tag;
            wr_valid_reg <= m_tag_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_idx_reg   <= s5_idx;
            m_cell_reg  <= s5_cell;
            wr_cell_reg <= m_cell_reg;
            wr_val_reg  <= value;
        end
    end

    assign m_tag   = m_tag_reg;
    assign m_idx   = m_idx_reg;
    assign m_value = value;

    // read data and forwarding state must freeze together while the pipe holds
    a_hold_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(rd_reg) && $stable(wr_valid_reg) && $stable(wr_cell_reg))
        else $error("accumulator read state moved during a hold");

endmodule

`default_nettype wire

// File: design/nchw_boolean_axis_reduce.sv
// top level: streaming and/or reduction over selected axes of an nchw boolean tensor
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+--------------------------------------
//  in       | in        | in_valid/in_stall  | element_bit
//  out      | out       | out_valid/out_stall| reduced_bit, out_index, tensor_done
//  cfg      | in        | cfg_wr_en          | cfg_addr, cfg_wdata (no read-back)
//
//  one word per cycle sustained while out_stall does not hold the pipe; a closing word
//  shows on out after the input stage register, the horner multiply chain (3 stages),
//  the constant modulo (2 stages), the accumulator ram read stage and the output register
//  the whole pipe moves together; in_stall is high while a result word waits on out_stall
//  reset clears positions, registers to their defaults and all pipe valids;
//  the accumulator ram is not cleared, every group's first word loads its cell
`default_nettype none

module nchw_boolean_axis_reduce #(
    parameter int ACC_DEPTH = 4096,
    parameter int DIM_MAX   = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input words
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          element_bit,
    // result words
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          reduced_bit,
    output logic [nbar_pkg::IDX_W-1:0]    out_index,
    output logic                          tensor_done,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [nbar_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [nbar_pkg::CFG_DW-1:0]   cfg_wdata
);
    import nbar_pkg::*;

    // position width follows the largest extent the clamp lets through
    localparam int EXT_MAX = (DIM_MAX < DIM_LIMIT) ? DIM_MAX : DIM_LIMIT;
    localparam int POS_W   = (EXT_MAX > 1) ? $clog2(EXT_MAX) : 1;
    localparam int CELL_W  = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

    // configuration registers
    logic [DIM_W-1:0]  dim_n_reg, dim_c_reg, dim_h_reg, dim_w_reg;
    logic [MODE_W-1:0] axis_mode_reg;
    logic              combine_op_reg;
    nbar_cfg_t         cfg;

    // pipe advance: move whenever the output slot is free or being taken
    logic adv;

    nbar_tag_t             s0_tag;
    logic [3:0][POS_W-1:0] s0_pos;
    logic [3:0][DIM_W-1:0] s0_ext;
    nbar_tag_t             s5_tag;
    logic [IDX_W-1:0]      s5_idx;
    logic [CELL_W-1:0]     s5_cell;
    nbar_tag_t             m_tag;
    logic [IDX_W-1:0]      m_idx;
    logic                  m_value;

    // output register
    logic              out_valid_reg;
    logic              reduced_bit_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic              tensor_done_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_n_reg      <= DIM_W'(1);
            dim_c_reg      <= DIM_W'(1);
            dim_h_reg      <= DIM_W'(1);
            dim_w_reg      <= DIM_W'(1);
            axis_mode_reg  <= MODE_N;
            combine_op_reg <= OP_AND;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_DIM_N:      dim_n_reg      <= cfg_wdata;
                REG_DIM_C:      dim_c_reg      <= cfg_wdata;
                REG_DIM_H:      dim_h_reg      <= cfg_wdata;
                REG_DIM_W:      dim_w_reg      <= cfg_wdata;
                REG_AXIS_MODE:  axis_mode_reg  <= cfg_wdata[MODE_W-1:0];
                REG_COMBINE_OP: combine_op_reg <= cfg_wdata[0];
                default:        ; // indexes past the list are dropped
            endcase
        end
    end

    always_comb
    begin
        cfg.dim_n      = dim_n_reg;
        cfg.dim_c      = dim_c_reg;
        cfg.dim_h      = dim_h_reg;
        cfg.dim_w      = dim_w_reg;
        cfg.axis_mode  = axis_mode_reg;
        cfg.combine_op = combine_op_reg;
    end

    // counters advanced on accept, open/close flags registered while the pipe advances
    nbar_pos #(
        .DIM_MAX (DIM_MAX),
        .POS_W   (POS_W)
    ) u_pos (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .elem     (element_bit),
        .cfg      (cfg),
        .s0_tag   (s0_tag),
        .s0_pos   (s0_pos),
        .s0_ext   (s0_ext)
    );

    // reduced-shape index and ram cell
    nbar_index #(
        .POS_W     (POS_W),
        .ACC_DEPTH (ACC_DEPTH),
        .CELL_W    (CELL_W)
    ) u_index (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .s0_tag  (s0_tag),
        .s0_pos  (s0_pos),
        .s0_ext  (s0_ext),
        .s5_tag  (s5_tag),
        .s5_idx  (s5_idx),
        .s5_cell (s5_cell)
    );

    // accumulator read-modify-write
    nbar_acc #(
        .ACC_DEPTH (ACC_DEPTH),
        .CELL_W    (CELL_W)
    ) u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .combine_op (combine_op_reg),
        .s5_tag     (s5_tag),
        .s5_idx     (s5_idx),
        .s5_cell    (s5_cell),
        .m_tag      (m_tag),
        .m_idx      (m_idx),
        .m_value    (m_value)
    );

    // only group-closing words reach the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= m_tag.valid && m_tag.closes;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            reduced_bit_reg <= m_value;
            out_index_reg   <= m_idx;
            tensor_done_reg <= m_tag.last_all;
        end
    end

    assign out_valid   = out_valid_reg;
    assign reduced_bit = reduced_bit_reg;
    assign out_index   = out_index_reg;
    assign tensor_done = tensor_done_reg;

    // a result word appears only after a closing word sat in the ram stage
    a_out_from_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(m_tag.valid && m_tag.closes))
        else $error("result word without a closing word");

endmodule

`default_nettype wire
